FILE: hw/rtl/nps_pkg.sv
// Shared types and constants of the nearest point search block.
package nps_pkg;

    localparam int COORD_W    = 24;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int DIST_W     = 2 * DIFF_W;
    localparam int SLOT_W     = 15;
    localparam int KIND_W     = 2;
    localparam int ECNT_W     = 3;
    localparam int USE_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = DIST_W;

    localparam logic [KIND_W-1:0] KIND_TABLE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_EXCL  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES_IN_USE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISTANCE_LIMIT = 2'd1;

    localparam logic [USE_W-1:0]  RST_ENTRIES_IN_USE = 16'd32768;
    localparam logic [DIST_W-1:0] RST_DISTANCE_LIMIT = 50'd6553600000;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
    } t_point;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH,
        ST_FINISH
    } t_state;

endpackage

FILE: hw/rtl/nps_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module nps_ram #(
    parameter int WIDTH = 72,
    parameter int DEPTH = 32768
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/nearest_point_search_with_exclusion.sv
// Top level of the nearest point search with exclusion list.
//
// Input channel (i_in_valid / o_in_stall) carries one request per item:
// kind 0 writes a table entry, kind 1 writes an exclusion slot, kind 2
// runs a query, kind 3 is dropped. Writes leave the input free and give no
// result. A query reads table entries 0 .. N-1 from the table RAM, one per
// cycle, where N is entries_in_use clamped to the table depth, and yields
// one result on the output channel (o_out_valid / i_out_stall).
// A query occupies the block until its result is registered: the RAM read port
// delivers one entry per cycle into a four-stage compare pipeline
// (difference, square, sum, best update), which drains before the result
// is registered. During a query o_in_stall stays high.
// The result sits in an output register; while the receiver stalls it
// holds, and writes may still be accepted. A finished query waits for the
// output register to free up before the block takes the next request.
// The configuration port (i_cfg_valid / o_cfg_ready) is always ready.
// Reset returns the control to idle and the control registers to their reset
// values; table and exclusion contents stay undefined until written.
module nearest_point_search_with_exclusion #(
    parameter int TABLE_DEPTH  = 32768,
    parameter int MAX_EXCLUDED = 4
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [nps_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [nps_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // request channel
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [nps_pkg::KIND_W-1:0]      i_kind,
    input  logic [nps_pkg::SLOT_W-1:0]      i_slot,
    input  logic signed [nps_pkg::COORD_W-1:0] i_point_x,
    input  logic signed [nps_pkg::COORD_W-1:0] i_point_y,
    input  logic signed [nps_pkg::COORD_W-1:0] i_point_z,
    input  logic [nps_pkg::ECNT_W-1:0]      i_exclusion_count,
    // result channel
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_found,
    output logic signed [nps_pkg::COORD_W-1:0] o_near_x,
    output logic signed [nps_pkg::COORD_W-1:0] o_near_y,
    output logic signed [nps_pkg::COORD_W-1:0] o_near_z
);

    import nps_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int XW = (MAX_EXCLUDED > 1) ? $clog2(MAX_EXCLUDED) : 1;

    // control registers
    t_state                  r_state, n_state;
    logic [AW-1:0]           r_addr, n_addr;
    logic [CW-1:0]           r_lim;
    logic [USE_W-1:0]        r_entries_in_use;
    logic [DIST_W-1:0]       r_distance_limit;
    logic                    r_v0, r_v1, r_v2, r_v3;
    logic                    r_have;
    logic                    r_out_valid;

    // payload registers
    logic [COORD_W-1:0]      r_qx, r_qy;
    logic [MAX_EXCLUDED-1:0] r_mask;
    logic [COORD_W-1:0]      r_ex_x [MAX_EXCLUDED];
    logic [COORD_W-1:0]      r_ex_y [MAX_EXCLUDED];
    t_point                  r_s1_row, r_s2_row, r_s3_row, r_best_row;
    logic signed [DIFF_W-1:0] r_s1_dx, r_s1_dy;
    logic                    r_s1_excl;
    logic [DIST_W-1:0]       r_s2_sqx, r_s2_sqy;
    logic [DIST_W-1:0]       r_s3_d;
    logic [DIST_W-1:0]       r_best_d;
    logic                    r_out_found;
    t_point                  r_out_row;

    logic                    w_in_acc;
    logic                    w_tbl_we;
    logic                    w_excl_we;
    logic                    w_query;
    logic                    w_rd_en;
    logic                    w_load_out;
    logic                    w_pipe_empty;
    logic                    w_last;
    logic                    w_excl_hit;
    logic                    w_better;
    logic [CW-1:0]           w_lim;
    logic [MAX_EXCLUDED-1:0] w_mask;
    logic [DIFF_W-1:0]       w_dx, w_dy;
    logic signed [DIST_W-1:0] w_sqx, w_sqy;
    t_point                  w_wrow;
    t_point                  w_rrow;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_in_acc    = i_in_valid && !o_in_stall;

    always_comb begin
        w_tbl_we  = 1'b0;
        w_excl_we = 1'b0;
        w_query   = 1'b0;
        unique case (i_kind)
            KIND_TABLE: w_tbl_we  = w_in_acc && (32'(i_slot) < TABLE_DEPTH);
            KIND_EXCL:  w_excl_we = w_in_acc && (32'(i_slot) < MAX_EXCLUDED);
            KIND_QUERY: w_query   = w_in_acc;
            default:    ;
        endcase
    end

    // clamp the scan length and build the active exclusion mask
    always_comb begin
        if (32'(r_entries_in_use) > TABLE_DEPTH) begin
            w_lim = CW'(TABLE_DEPTH);
        end else begin
            w_lim = CW'(r_entries_in_use);
        end
        for (int j = 0; j < MAX_EXCLUDED; j++) begin
            w_mask[j] = (32'(i_exclusion_count) > j);
        end
    end

    assign w_wrow = '{x: i_point_x, y: i_point_y, z: i_point_z};

    nps_ram #(
        .WIDTH ($bits(t_point)),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_tbl_we),
        .i_waddr (AW'(i_slot)),
        .i_wdata (w_wrow),
        .i_re    (w_rd_en),
        .i_raddr (r_addr),
        .o_rdata (w_rrow)
    );

    assign w_pipe_empty = !r_v0 && !r_v1 && !r_v2 && !r_v3;
    assign w_last       = (CW'(r_addr) == r_lim - CW'(1));

    always_comb begin
        n_state    = r_state;
        n_addr     = r_addr;
        w_rd_en    = 1'b0;
        w_load_out = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                n_addr = '0;
                if (w_query) begin
                    n_state = (w_lim == '0) ? ST_FINISH : ST_SCAN;
                end
            end
            ST_SCAN: begin
                w_rd_en = 1'b1;
                n_addr  = r_addr + AW'(1);
                if (w_last) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (w_pipe_empty) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!r_out_valid || !i_out_stall) begin
                    w_load_out = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // exclusion check and planar differences on the entry just read
    always_comb begin
        w_excl_hit = 1'b0;
        for (int j = 0; j < MAX_EXCLUDED; j++) begin
            if (r_mask[j] && w_rrow.x == r_ex_x[j] && w_rrow.y == r_ex_y[j]) begin
                w_excl_hit = 1'b1;
            end
        end
        w_dx = {w_rrow.x[COORD_W-1], w_rrow.x} - {r_qx[COORD_W-1], r_qx};
        w_dy = {w_rrow.y[COORD_W-1], w_rrow.y} - {r_qy[COORD_W-1], r_qy};
    end

    assign w_sqx    = r_s1_dx * r_s1_dx;
    assign w_sqy    = r_s1_dy * r_s1_dy;
    assign w_better = r_v3 && (r_s3_d < r_distance_limit) && (!r_have || r_s3_d < r_best_d);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= ST_IDLE;
            r_addr           <= '0;
            r_lim            <= '0;
            r_entries_in_use <= RST_ENTRIES_IN_USE;
            r_distance_limit <= RST_DISTANCE_LIMIT;
            r_v0             <= 1'b0;
            r_v1             <= 1'b0;
            r_v2             <= 1'b0;
            r_v3             <= 1'b0;
            r_have           <= 1'b0;
            r_out_valid      <= 1'b0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_ENTRIES_IN_USE: r_entries_in_use <= i_cfg_data[USE_W-1:0];
                    CFG_DISTANCE_LIMIT: r_distance_limit <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_query) begin
                r_lim  <= w_lim;
                r_have <= 1'b0;
            end else if (w_better) begin
                r_have <= 1'b1;
            end
            r_v0 <= w_rd_en;
            r_v1 <= r_v0;
            // drop excluded entries here
            r_v2 <= r_v1 && !r_s1_excl;
            r_v3 <= r_v2;
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_query) begin
            r_qx   <= i_point_x;
            r_qy   <= i_point_y;
            r_mask <= w_mask;
        end
        if (w_excl_we) begin
            r_ex_x[XW'(i_slot)] <= i_point_x;
            r_ex_y[XW'(i_slot)] <= i_point_y;
        end
        r_s1_row  <= w_rrow;
        r_s1_dx   <= w_dx;
        r_s1_dy   <= w_dy;
        r_s1_excl <= w_excl_hit;
        r_s2_row  <= r_s1_row;
        r_s2_sqx  <= $unsigned(w_sqx);
        r_s2_sqy  <= $unsigned(w_sqy);
        r_s3_row  <= r_s2_row;
        r_s3_d    <= r_s2_sqx + r_s2_sqy;
        if (w_better) begin
            r_best_d   <= r_s3_d;
            r_best_row <= r_s3_row;
        end
        if (w_load_out) begin
            r_out_found <= r_have;
            r_out_row   <= r_have ? r_best_row : '0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_found     = r_out_found;
    assign o_near_x    = r_out_row.x;
    assign o_near_y    = r_out_row.y;
    assign o_near_z    = r_out_row.z;

endmodule
